### rtl/cip_pkg.sv
`default_nettype none

package cip_pkg;

  // capacity and field widths
  localparam int unsigned MAX_ITEMS  = 1024;
  localparam int unsigned SCORE_BITS = 32;
  localparam int unsigned ADDR_W     = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W      = ADDR_W + 1;
  localparam int unsigned HALF_W     = 20;
  localparam int unsigned PAIR_W     = 19;
  localparam int unsigned CIDX_W     = 17;

  // saturation limits of the running counters
  localparam logic [HALF_W-1:0] HALF_MAX = {HALF_W{1'b1}};
  localparam logic [PAIR_W-1:0] PAIR_MAX = {PAIR_W{1'b1}};

  // ratio in Q1.16, one step of the divider per fraction bit
  localparam int unsigned            FRAC_BITS = 16;
  localparam int unsigned            STEP_W    = $clog2(FRAC_BITS);
  localparam logic [CIDX_W-1:0]      ONE_Q16   = CIDX_W'(1) << FRAC_BITS;

  // request into the ratio divider
  typedef struct packed {
    logic              start;
    logic [HALF_W-1:0] half;
    logic [PAIR_W-1:0] pair;
  } div_req_t;

  // status back from the ratio divider
  typedef struct packed {
    logic              done;
    logic [CIDX_W-1:0] c_index;
    logic              no_pairs;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/cip_ifs.sv
`default_nettype none

// input channel: one scored item per transfer
interface cip_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cip_pkg::SCORE_BITS-1:0] score;
  logic                                  label;
  logic                                  last;

  modport source (output valid, output score, output label, output last, input ready);
  modport sink (input valid, input score, input label, input last, output ready);
endinterface

// output channel: one result per closed set
interface cip_out_if;
  logic                             valid;
  logic                             ready;
  logic [cip_pkg::HALF_W-1:0]       concordant_halves;
  logic [cip_pkg::PAIR_W-1:0]       total_pairs;
  logic [cip_pkg::CIDX_W-1:0]       c_index;
  logic                             no_pairs;
  logic                             overflowed;

  modport source (output valid, output concordant_halves, output total_pairs,
                  output c_index, output no_pairs, output overflowed, input ready);
  modport sink (input valid, input concordant_halves, input total_pairs,
                input c_index, input no_pairs, input overflowed, output ready);
endinterface

`default_nettype wire

### rtl/cip_div.sv
`default_nettype none

// restoring divider for the Q1.16 ratio half / (2 * pair), one quotient bit a cycle
module cip_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cip_pkg::div_req_t req_i,
  output cip_pkg::div_rsp_t rsp_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [cip_pkg::STEP_W-1:0]   step_q;
  logic [cip_pkg::HALF_W-1:0]   rem_q;
  logic [cip_pkg::PAIR_W-1:0]   div_q;
  logic [cip_pkg::CIDX_W-1:0]   quo_q;
  logic                         none_q;

  logic [cip_pkg::HALF_W:0]     diff;
  logic                         qbit;
  logic [cip_pkg::HALF_W-1:0]   rem_keep;
  logic                         saturate;

  // ratio reaches one exactly when half >= 2 * pair
  assign saturate = req_i.half >= {req_i.pair, 1'b0};

  // trial subtract of the divisor
  assign diff     = {1'b0, rem_q} - {2'b00, div_q};
  assign qbit     = ~diff[cip_pkg::HALF_W];
  assign rem_keep = qbit ? diff[cip_pkg::HALF_W-1:0] : rem_q;

  // sequencer and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        step_q <= '0;
        if (req_i.pair == '0 || saturate) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        step_q <= step_q + cip_pkg::STEP_W'(1);
        if (step_q == cip_pkg::STEP_W'(cip_pkg::FRAC_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.half;
      div_q  <= req_i.pair;
      none_q <= (req_i.pair == '0);
      if (req_i.pair == '0) begin
        quo_q <= '0;
      end else if (saturate) begin
        quo_q <= cip_pkg::ONE_Q16;
      end else begin
        quo_q <= '0;
      end
    end else if (busy_q) begin
      rem_q <= {rem_keep[cip_pkg::HALF_W-2:0], 1'b0};
      quo_q <= {quo_q[cip_pkg::CIDX_W-2:0], qbit};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.c_index  = quo_q;
  assign rsp_o.no_pairs = none_q;

endmodule

`default_nettype wire

### rtl/concordance_index_pairwise_core.sv
// Concordance index (pairwise AUC) over a set of labeled prediction scores.
// in_i carries one item per transfer: score (signed key), label and last.
// Each accepted item that finds room is stored and compared against every
// earlier item of the set, one stored item per cycle through a single
// comparator reading the item memory. After its transfer an item holds
// in_i.ready low while the scan reads the items already stored, so the
// next transfer waits for that scan. A first or dropped item not marked
// last needs no scan and leaves in_i.ready high. Items past 1024 are
// dropped and flagged. An item marked last closes the set: after its scan
// the ratio divider runs (skipping its steps when there are no pairs or
// the ratio is one), then the finish step loads the output register and
// out_o presents concordant_halves, total_pairs, c_index (Q1.16,
// floored), no_pairs and overflowed until taken. in_i.ready is low while
// an item is scanned or a result is being formed. If out_o stalls with a
// result still held, the next result waits in the finish step until the
// register frees. Reset clears the counters and the handshake state;
// memory contents need no clearing since only entries of the current set
// are read.
`default_nettype none

module concordance_index_pairwise_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  cip_in_if.sink     in_i,
  cip_out_if.source  out_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DIVW   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  localparam int unsigned WORD_W = cip_pkg::SCORE_BITS + 1;

  logic [1:0]                            state_q, state_d;
  logic [cip_pkg::CNT_W-1:0]             count_q;
  logic [cip_pkg::CNT_W-1:0]             len_q;
  logic [cip_pkg::CNT_W-1:0]             iss_q;
  logic                                  rv_q;
  logic signed [cip_pkg::SCORE_BITS-1:0] key_q;
  logic                                  lab_q;
  logic                                  last_q;
  logic [cip_pkg::HALF_W-1:0]            half_q;
  logic [cip_pkg::PAIR_W-1:0]            pair_q;
  logic                                  drop_q;

  logic [WORD_W-1:0]                     mem [cip_pkg::MAX_ITEMS];
  logic [WORD_W-1:0]                     rd_q;

  logic                                  out_valid_q;
  logic [cip_pkg::HALF_W-1:0]            out_half_q;
  logic [cip_pkg::PAIR_W-1:0]            out_pair_q;
  logic [cip_pkg::CIDX_W-1:0]            out_cidx_q;
  logic                                  out_none_q;
  logic                                  out_ovf_q;

  logic                                  acc;
  logic                                  has_room;
  logic                                  issue;
  logic                                  scan_done;
  logic                                  load;
  logic signed [cip_pkg::SCORE_BITS-1:0] other;
  logic signed [cip_pkg::SCORE_BITS-1:0] pos;
  logic signed [cip_pkg::SCORE_BITS-1:0] neg;
  logic                                  opposite;
  logic [1:0]                            add;
  logic [cip_pkg::HALF_W:0]              half_sum;
  logic [cip_pkg::HALF_W-1:0]            half_next;
  logic [cip_pkg::PAIR_W-1:0]            pair_next;

  cip_pkg::div_req_t                     div_req;
  cip_pkg::div_rsp_t                     div_rsp;

  // handshake
  assign in_i.ready = (state_q == S_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign has_room   = count_q < cip_pkg::CNT_W'(cip_pkg::MAX_ITEMS);
  assign issue      = (state_q == S_SCAN) && (iss_q < len_q);
  assign scan_done  = (state_q == S_SCAN) && !issue && !rv_q;
  assign load       = (state_q == S_FINISH) && (!out_valid_q || out_o.ready);

  // item memory: write on transfer while room remains, registered read during the scan
  always_ff @(posedge clk_i) begin
    if (acc && has_room) begin
      mem[count_q[cip_pkg::ADDR_W-1:0]] <= {in_i.label, in_i.score};
    end
    if (issue) begin
      rd_q <= mem[iss_q[cip_pkg::ADDR_W-1:0]];
    end
  end

  // shared compare unit: new item against one stored item
  assign other     = rd_q[cip_pkg::SCORE_BITS-1:0];
  assign opposite  = rd_q[WORD_W-1] != lab_q;
  assign pos       = lab_q ? key_q : other;
  assign neg       = lab_q ? other : key_q;
  assign add       = (pos > neg) ? 2'd2 : ((pos == neg) ? 2'd1 : 2'd0);
  assign half_sum  = {1'b0, half_q} + (cip_pkg::HALF_W + 1)'(add);
  assign half_next = (half_sum > {1'b0, cip_pkg::HALF_MAX}) ? cip_pkg::HALF_MAX
                                                            : half_sum[cip_pkg::HALF_W-1:0];
  assign pair_next = (pair_q == cip_pkg::PAIR_MAX) ? pair_q
                                                   : pair_q + cip_pkg::PAIR_W'(1);

  // sequencer
  always_comb begin
    state_d       = state_q;
    div_req.start = 1'b0;
    div_req.half  = half_q;
    div_req.pair  = pair_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (has_room && count_q != '0) begin
            state_d = S_SCAN;
          end else if (in_i.last) begin
            state_d       = S_DIVW;
            div_req.start = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          if (last_q) begin
            state_d       = S_DIVW;
            div_req.start = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state and running counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      len_q   <= '0;
      iss_q   <= '0;
      rv_q    <= 1'b0;
      half_q  <= '0;
      pair_q  <= '0;
      drop_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= issue;
      if (acc) begin
        last_q <= in_i.last;
        if (has_room) begin
          count_q <= count_q + cip_pkg::CNT_W'(1);
          len_q   <= count_q;
          iss_q   <= '0;
        end else begin
          drop_q <= 1'b1;
        end
      end
      if (issue) begin
        iss_q <= iss_q + cip_pkg::CNT_W'(1);
      end
      if (rv_q && opposite) begin
        half_q <= half_next;
        pair_q <= pair_next;
      end
      if (load) begin
        count_q <= '0;
        half_q  <= '0;
        pair_q  <= '0;
        drop_q  <= 1'b0;
      end
    end
  end

  // captured item key
  always_ff @(posedge clk_i) begin
    if (acc) begin
      key_q <= in_i.score;
      lab_q <= in_i.label;
    end
  end

  cip_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_half_q <= half_q;
      out_pair_q <= pair_q;
      out_cidx_q <= div_rsp.c_index;
      out_none_q <= div_rsp.no_pairs;
      out_ovf_q  <= drop_q;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.concordant_halves = out_half_q;
  assign out_o.total_pairs       = out_pair_q;
  assign out_o.c_index           = out_cidx_q;
  assign out_o.no_pairs          = out_none_q;
  assign out_o.overflowed        = out_ovf_q;

`ifndef SYNTHESIS
  // stored item count never passes capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cip_pkg::CNT_W'(cip_pkg::MAX_ITEMS))
    else $error("item count beyond capacity");

  // divider reports only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIVW)
    else $error("divider done outside wait step");

  // a new result appears only out of the finish step
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FINISH)
    else $error("result valid without finish step");

  // ratio never exceeds one
  a_ratio_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |=> div_rsp.c_index <= cip_pkg::ONE_Q16)
    else $error("ratio above one");
`endif

endmodule

`default_nettype wire
